[rtl/core/line_substring_matcher_unit_assert.svh]
// ----------------------------------------------------------------------------
// line substring matcher assertion macros
// concurrent assertion shorthands clocked on clk_i, disabled during reset
// ----------------------------------------------------------------------------
`ifndef LINE_SUBSTRING_MATCHER_UNIT_ASSERT_SVH
`define LINE_SUBSTRING_MATCHER_UNIT_ASSERT_SVH

// same-cycle implication
`define LSM_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define LSM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/core/lsm_pkg.sv]
// ----------------------------------------------------------------------------
// lsm_pkg
// shared types, constants and helpers of the line substring matcher
// ----------------------------------------------------------------------------
package lsm_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int PAT_REGS    = 4;
  localparam int PAT_REG_W   = 64;
  localparam int BYTES_PER_REG = PAT_REG_W / 8;
  localparam int LEN_W       = 6;
  localparam int CNT_W       = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int CFG_IDX_W   = 3;

  typedef logic [7:0] byte_t;

  localparam byte_t NEWLINE       = 8'd10;
  localparam byte_t ASCII_UPPER_A = 8'd65;
  localparam byte_t ASCII_UPPER_Z = 8'd90;
  localparam byte_t CASE_OFFSET   = 8'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT0        = 3'd0,
    REG_PAT1        = 3'd1,
    REG_PAT2        = 3'd2,
    REG_PAT3        = 3'd3,
    REG_LEN         = 3'd4,
    REG_IGNORE_CASE = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [PATTERN_MAX-1:0][7:0] pattern;
    logic [CNT_W-1:0]            eff_len;
    logic                        ignore_case;
  } cfg_t;

  typedef struct packed {
    logic produce;
    logic line_matched;
    logic any_matched;
    logic final_verdict;
  } res_t;

  function automatic byte_t fold_byte(byte_t c, logic ic);
    byte_t r;
    r = c;
    if (ic && (c >= ASCII_UPPER_A) && (c <= ASCII_UPPER_Z)) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

[rtl/core/lsm_cfg_regs.sv]
// ----------------------------------------------------------------------------
// lsm_cfg_regs
// pattern, length and case-fold registers with the clamped match length
// ----------------------------------------------------------------------------
module lsm_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wr_en_i,
  input  logic [lsm_pkg::CFG_IDX_W-1:0]       wr_index_i,
  input  logic [lsm_pkg::PAT_REG_W-1:0]       wr_data_i,
  output lsm_pkg::cfg_t                       cfg_o
);
  import lsm_pkg::*;

  logic [PAT_REGS-1:0][PAT_REG_W-1:0] pat_q;
  logic [LEN_W-1:0]                   len_q;
  logic                               ic_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= '0;
      len_q <= LEN_W'(1);
      ic_q  <= 1'b0;
    end else if (wr_en_i) begin
      case (cfg_reg_e'(wr_index_i))
        REG_PAT0:        pat_q[0] <= wr_data_i;
        REG_PAT1:        pat_q[1] <= wr_data_i;
        REG_PAT2:        pat_q[2] <= wr_data_i;
        REG_PAT3:        pat_q[3] <= wr_data_i;
        REG_LEN:         len_q    <= wr_data_i[LEN_W-1:0];
        REG_IGNORE_CASE: ic_q     <= wr_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      // bytes beyond the register file read as zero
      if (i < PAT_REGS * BYTES_PER_REG) begin
        cfg_o.pattern[i] = pat_q[i / BYTES_PER_REG][(i % BYTES_PER_REG) * 8 +: 8];
      end else begin
        cfg_o.pattern[i] = '0;
      end
    end
    if (len_q == '0) begin
      cfg_o.eff_len = CNT_W'(1);
    end else if (int'(len_q) > PATTERN_MAX) begin
      cfg_o.eff_len = CNT_W'(PATTERN_MAX);
    end else begin
      cfg_o.eff_len = CNT_W'(len_q);
    end
    cfg_o.ignore_case = ic_q;
  end

endmodule

[rtl/core/lsm_window_match.sv]
// ----------------------------------------------------------------------------
// lsm_window_match
// recent-byte window, line byte count, hit flags and per-byte window compare
// ----------------------------------------------------------------------------
module lsm_window_match (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  lsm_pkg::byte_t byte_i,
  input  logic           last_i,
  input  lsm_pkg::cfg_t  cfg_i,
  output lsm_pkg::res_t  res_o
);
  import lsm_pkg::*;

  logic [PATTERN_MAX-1:0][7:0] win_q, win_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic                        line_hit_q, line_hit_d;
  logic                        any_hit_q, any_hit_d;
  logic                        is_nl;
  logic                        all_eq;
  logic [CNT_W-1:0]            pidx;

  always_comb begin
    is_nl = (byte_i == NEWLINE);

    // window after this byte, newest in slot 0
    win_d = {win_q[PATTERN_MAX-2:0], byte_i};
    if (cnt_q < CNT_W'(PATTERN_MAX)) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else begin
      cnt_d = cnt_q;
    end

    // slot k lines up with pattern byte eff_len-1-k
    all_eq = 1'b1;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      pidx = cfg_i.eff_len - CNT_W'(1) - CNT_W'(k);
      if (CNT_W'(k) < cfg_i.eff_len) begin
        if (fold_byte(win_d[k], cfg_i.ignore_case) !=
            fold_byte(cfg_i.pattern[pidx[IDX_W-1:0]], cfg_i.ignore_case)) begin
          all_eq = 1'b0;
        end
      end
    end

    line_hit_d = line_hit_q;
    any_hit_d  = any_hit_q;
    if (!is_nl && (cnt_d >= cfg_i.eff_len) && all_eq) begin
      line_hit_d = 1'b1;
      any_hit_d  = 1'b1;
    end

    res_o.produce       = is_nl || last_i;
    res_o.line_matched  = line_hit_d;
    res_o.any_matched   = any_hit_d;
    res_o.final_verdict = last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= '0;
      cnt_q      <= '0;
      line_hit_q <= 1'b0;
      any_hit_q  <= 1'b0;
    end else if (step_i) begin
      any_hit_q <= any_hit_d;
      if (res_o.produce) begin
        // line closed: start the next one empty
        win_q      <= '0;
        cnt_q      <= '0;
        line_hit_q <= 1'b0;
      end else begin
        win_q      <= win_d;
        cnt_q      <= cnt_d;
        line_hit_q <= line_hit_d;
      end
    end
  end

endmodule

[rtl/core/line_substring_matcher_unit.sv]
// the verdict of a line leaves its closing byte through the input register, then the verdict register
// throughput: one byte per cycle unless a full verdict register is stalled; a verdict register and an
// input register decouple the sides; the combinational 32-byte window compare between them sets the rate
// reset (async, active low): window, line count, hit flags and both pipe stages clear,
// pattern registers go to zero, pattern length to one and case folding off
// ----------------------------------------------------------------------------
// line_substring_matcher_unit
// fixed-string line filter: flags each text line that holds the configured pattern
// ----------------------------------------------------------------------------
module line_substring_matcher_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lsm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lsm_pkg::PAT_REG_W-1:0]     cfg_data_i,
  // text byte stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] text_byte
  input  logic                              s_axis_tlast,  // stream_end
  // verdict stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,  // [0] line_matched,
                                                           // [1] any_line_matched, [7:2] zero
  output logic                              m_axis_tlast   // final_verdict
);
  import lsm_pkg::*;

  cfg_t  cfg;
  res_t  res;

  // input register
  logic  in_valid_q;
  byte_t in_byte_q;
  logic  in_last_q;

  // verdict register
  logic  out_valid_q;
  logic  out_line_q;
  logic  out_any_q;
  logic  out_final_q;

  logic  advance;   // verdict slot free or emptying this cycle
  logic  step;      // byte in the input register is processed

  // configuration is always accepted
  assign cfg_ready_o = 1'b1;

  lsm_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  // input stage: refills whenever it empties or is empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // window update and compare for the byte in the input register
  lsm_window_match u_win (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // verdict stage: loads only for bytes that close a line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && res.produce;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.produce) begin
      out_line_q  <= res.line_matched;
      out_any_q   <= res.any_matched;
      out_final_q <= res.final_verdict;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_any_q, out_line_q};
  assign m_axis_tlast  = out_final_q;

`include "line_substring_matcher_unit_assert.svh"

  // a matching line always sets the sticky flag
  `LSM_ASSERT_NOW(a_line_implies_any, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[1], "line match without sticky flag")
  // input stalls only behind a full, blocked verdict register
  `LSM_ASSERT_NOW(a_stall_cause, !s_axis_tready, out_valid_q && !m_axis_tready && in_valid_q, "input stalled without back-pressure")
  // an accepted byte lands in the input register
  `LSM_ASSERT_NEXT(a_accept_loads, s_axis_tvalid && s_axis_tready, in_valid_q, "accepted byte lost")

endmodule

[bench/tb_line_substring_matcher_unit.sv]
// ----------------------------------------------------------------------------
// tb_line_substring_matcher_unit
// self-checking bench for the fixed-string line filter: text bytes stream in,
// a cycle-free predictor computes one verdict per closed line, and each verdict
// transaction on the master side is compared with the oldest predicted one
// ----------------------------------------------------------------------------
module tb_line_substring_matcher_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lsm_pkg::*;

  localparam int RANDOM_BYTES  = 550;   // text bytes in the random part
  localparam int IDLE_PCT      = 33;    // chance of an idle cycle on either side
  localparam int SETTLE_CYCLES = 8;     // margin for the pipe to run empty after the last verdict
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off, fills the block
  localparam int STALL_LIMIT   = 2000;  // cycles without any transaction before giving up
  localparam byte_t LOWER_A    = 8'd97;
  localparam byte_t LOWER_Z    = 8'd122;

  // one verdict as the master side carries it
  typedef struct packed {
    logic line_matched;
    logic any_matched;
    logic final_verdict;
  } verdict_t;

  // --------------------------------------------------------------------------
  // line verdict predictor: pattern settings, the window of the open line and
  // the queue of verdicts still owed by the block
  // --------------------------------------------------------------------------
  class line_verdicts;
    logic [PAT_REG_W-1:0] pat_regs [PAT_REGS];
    logic [LEN_W-1:0]     pat_len;
    logic                 case_fold;
    byte_t                window [PATTERN_MAX];  // newest byte first
    int unsigned          line_fill;             // saturates at PATTERN_MAX
    logic                 line_hit;
    logic                 any_hit;
    verdict_t             due[$];
    int unsigned          bytes_seen;
    int unsigned          checked;
    int unsigned          lines_hit;
    int unsigned          stream_ends;
    int unsigned          errors;

    function new();
      foreach (pat_regs[i]) pat_regs[i] = '0;
      pat_len     = LEN_W'(1);
      case_fold   = 1'b0;
      any_hit     = 1'b0;
      bytes_seen  = 0;
      checked     = 0;
      lines_hit   = 0;
      stream_ends = 0;
      errors      = 0;
      clear_line();
    endfunction

    function void clear_line();
      foreach (window[i]) window[i] = '0;
      line_fill = 0;
      line_hit  = 1'b0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [PAT_REG_W-1:0] data);
      case (idx)
        REG_PAT0:        pat_regs[0] = data;
        REG_PAT1:        pat_regs[1] = data;
        REG_PAT2:        pat_regs[2] = data;
        REG_PAT3:        pat_regs[3] = data;
        REG_LEN:         pat_len = data[LEN_W-1:0];
        REG_IGNORE_CASE: case_fold = data[0];
        default: ;
      endcase
    endfunction

    // A-Z map onto a-z by setting bit 5, only while folding is on
    function byte_t lower(byte_t c);
      if (case_fold && c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) return c | 8'h20;
      return c;
    endfunction

    function int effective_len();
      if (pat_len == 0) return 1;
      if (pat_len > PATTERN_MAX) return PATTERN_MAX;
      return int'(pat_len);
    endfunction

    function bit window_hit();
      int n;
      n = effective_len();
      if (line_fill < n) return 1'b0;
      for (int i = 0; i < n; i++) begin
        if (lower(window[n-1-i]) != lower(pat_regs[i/8][(i%8)*8 +: 8])) return 1'b0;
      end
      return 1'b1;
    endfunction

    // accepted text byte: a newline or the stream end closes the line
    function void take_byte(byte_t c, logic last);
      verdict_t v;
      bytes_seen++;
      if (c != NEWLINE) begin
        for (int i = PATTERN_MAX - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = c;
        if (line_fill < PATTERN_MAX) line_fill++;
        if (window_hit()) begin
          line_hit = 1'b1;
          any_hit  = 1'b1;
        end
        if (!last) return;
      end
      v.line_matched  = line_hit;
      v.any_matched   = any_hit;
      v.final_verdict = last;
      due.push_back(v);
      if (line_hit) lines_hit++;
      if (last) stream_ends++;
      clear_line();
    endfunction

    function void check_verdict(logic [7:0] data, logic last);
      verdict_t want;
      if (due.size() == 0) begin
        $error("verdict with no closed line: line_matched %0d any_line_matched %0d final %0d",
               data[0], data[1], last);
        errors++;
        return;
      end
      want = due.pop_front();
      checked++;
      if (data[0] !== want.line_matched) begin
        $error("line_matched: expected %0d, actual %0d", want.line_matched, data[0]);
        errors++;
      end
      if (data[1] !== want.any_matched) begin
        $error("any_line_matched: expected %0d, actual %0d", want.any_matched, data[1]);
        errors++;
      end
      if (last !== want.final_verdict) begin
        $error("final_verdict: expected %0d, actual %0d", want.final_verdict, last);
        errors++;
      end
      if (data[7:2] !== 6'd0) begin
        $error("tdata padding: expected 0, actual %0h", data[7:2]);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block ports, all inputs known from time zero
  // --------------------------------------------------------------------------
  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [PAT_REG_W-1:0] cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;  // [7:0] text_byte
  logic                 s_axis_tlast  = 1'b0;  // stream_end
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;  // [0] line_matched, [1] any_line_matched, [7:2] zero
  logic                 m_axis_tlast;  // final_verdict

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  line_substring_matcher_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  line_verdicts verdicts;
  byte_t        pat_text [PATTERN_MAX];  // pattern as last loaded, also feeds line building
  byte_t        line_text[$];            // the line about to be sent
  bit           steady    = 1'b0;        // no idle cycles on either side while set
  bit           hold_req  = 1'b0;        // asks the receiver for one long hold-off
  int unsigned  settings  = 0;
  int unsigned  stall_cnt = 0;

  // --------------------------------------------------------------------------
  // receiver: checks each verdict transaction, idles at random, and runs the
  // long hold-off on request with its own cycle count
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        verdicts.check_verdict(m_axis_tdata, m_axis_tlast);
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // watchdog: any transaction on any channel restarts the count
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("stalled for %0d cycles with %0d verdicts outstanding",
               stall_cnt, verdicts.due.size());
      $display("tb_line_substring_matcher_unit failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // one text byte; tvalid stays high afterwards so back-to-back bytes need no
  // second assignment in the same step
  task automatic send_byte(input byte_t c, input logic last);
    int gap;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(0, 99) < IDLE_PCT) gap++;
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    verdicts.take_byte(c, last);
  endtask

  // sender pauses until every verdict is in, then lets the pipe run empty,
  // since bytes that close nothing can still be in flight
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (verdicts.due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [PAT_REG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    verdicts.write_reg(idx, data);
  endtask

  function automatic logic [PAT_REG_W-1:0] pack_word(input int r);
    logic [PAT_REG_W-1:0] w;
    for (int b = 0; b < BYTES_PER_REG; b++) w[b*8 +: 8] = pat_text[r*BYTES_PER_REG + b];
    return w;
  endfunction

  // loads pat_text plus length and case words while the block is idle
  task automatic load_setting(input logic [PAT_REG_W-1:0] len_word,
                              input logic [PAT_REG_W-1:0] ic_word);
    settle();
    write_reg(REG_PAT0, pack_word(0));
    write_reg(REG_PAT1, pack_word(1));
    write_reg(REG_PAT2, pack_word(2));
    write_reg(REG_PAT3, pack_word(3));
    write_reg(REG_LEN, len_word);
    write_reg(REG_IGNORE_CASE, ic_word);
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  task automatic send_line(input bit close_stream);
    foreach (line_text[i]) begin
      send_byte(line_text[i], close_stream && (i == line_text.size() - 1));
    end
  endtask

  // --------------------------------------------------------------------------
  // line building for the random part
  // --------------------------------------------------------------------------
  function automatic byte_t flip_case(input byte_t c);
    if (((c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) || (c >= LOWER_A && c <= LOWER_Z)) &&
        $urandom_range(0, 1)) begin
      return c ^ CASE_OFFSET;
    end
    return c;
  endfunction

  // half the filler comes from the pattern itself so near matches are common
  function automatic byte_t filler_byte();
    byte_t c;
    if ($urandom_range(0, 1)) c = pat_text[$urandom_range(0, verdicts.effective_len() - 1)];
    else c = byte_t'($urandom_range(0, 255));
    if (c == NEWLINE) c = 8'h20;
    return flip_case(c);
  endfunction

  function automatic int filler_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 45);  // long line
    return $urandom_range(0, 6);
  endfunction

  task automatic make_line(input bit close_stream);
    int    kind;
    int    n;
    int    miss_at;
    byte_t c;
    kind = $urandom_range(0, 9);
    n    = verdicts.effective_len();
    line_text.delete();
    repeat (filler_len()) line_text.push_back(filler_byte());
    if (kind < 5) begin
      // whole pattern, case scrambled when folding is on
      for (int i = 0; i < n; i++) begin
        line_text.push_back(verdicts.case_fold ? flip_case(pat_text[i]) : pat_text[i]);
      end
    end else if (kind < 7) begin
      // near miss: one bit of one pattern byte flipped
      miss_at = $urandom_range(0, n - 1);
      for (int i = 0; i < n; i++) begin
        c = pat_text[i];
        if (i == miss_at) c = c ^ byte_t'(1 << $urandom_range(0, 7));
        if (c == NEWLINE) c = 8'h0B;
        line_text.push_back(c);
      end
    end else if (kind == 9) begin
      // noise, stray newlines included
      repeat ($urandom_range(1, 12)) line_text.push_back(byte_t'($urandom_range(0, 255)));
    end
    repeat (filler_len() / 2) line_text.push_back(filler_byte());
    // a stream may end on an ordinary byte or on its newline
    if (!(close_stream && line_text.size() > 0 && $urandom_range(0, 1))) begin
      line_text.push_back(NEWLINE);
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned     start_bytes;
    int unsigned     target;
    int              phase;
    int              len;
    bit              close_stream;
    logic [PAT_REG_W-1:0] len_word;
    logic [PAT_REG_W-1:0] ic_word;
    verdicts = new();
    foreach (pat_text[i]) pat_text[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: pattern is a single NUL, no folding
    send_byte(8'hFF, 1'b0);
    send_byte("A", 1'b0);
    send_byte(NEWLINE, 1'b0);
    send_byte(NEWLINE, 1'b0);     // empty line
    send_byte("A", 1'b1);         // stream ends on an ordinary byte

    // a pattern holding a newline can never match
    pat_text[0] = "x";
    pat_text[1] = NEWLINE;
    load_setting(64'd2, 64'd0);
    send_byte("x", 1'b0);
    send_byte(NEWLINE, 1'b0);

    // folding switched on in the middle of an open line
    pat_text[0] = "A";
    pat_text[1] = "b";
    load_setting(64'd2, 64'd0);
    send_byte("a", 1'b0);
    load_setting(64'd2, 64'd1);
    send_byte("B", 1'b0);
    send_byte(NEWLINE, 1'b0);

    // same pattern, exact case again
    load_setting(64'd2, 64'd0);
    send_byte("a", 1'b0);
    send_byte("B", 1'b1);
    send_byte("A", 1'b0);
    send_byte("b", 1'b0);
    send_byte(NEWLINE, 1'b0);
    send_byte(NEWLINE, 1'b1);     // stream ends on its newline

    // length zero acts as one, NUL compared as is
    pat_text[0] = 8'h00;
    load_setting(64'd0, 64'd0);
    send_byte(8'h00, 1'b0);
    send_byte(NEWLINE, 1'b0);

    // random part: one pattern setting per phase, lengths cycling through the
    // extremes and the out-of-range codes
    start_bytes = verdicts.bytes_seen;
    phase = 0;
    while (verdicts.bytes_seen < start_bytes + RANDOM_BYTES) begin
      case (phase % 6)
        0:       len = 1;
        1:       len = PATTERN_MAX;
        2:       len = 0;
        3:       len = $urandom_range(2, 6);
        4:       len = $urandom_range(PATTERN_MAX + 1, 63);
        default: len = $urandom_range(7, PATTERN_MAX - 1);
      endcase
      foreach (pat_text[i]) begin
        if (phase % 4 == 3) pat_text[i] = byte_t'($urandom_range(0, 255));
        else pat_text[i] = flip_case(LOWER_A + byte_t'($urandom_range(0, 3)));
      end
      len_word = {$urandom, $urandom};
      len_word[LEN_W-1:0] = LEN_W'(len);
      ic_word = {$urandom, $urandom};
      steady = 1'b0;
      load_setting(len_word, ic_word);

      // one phase with no idling at all, one with the long receiver hold-off
      steady = (phase == 5);
      if (phase == 3) hold_req = 1'b1;

      target = verdicts.bytes_seen + $urandom_range(35, 60);
      while (verdicts.bytes_seen < target) begin
        close_stream = ($urandom_range(0, 6) == 0);
        make_line(close_stream);
        send_line(close_stream);
      end
      phase++;
    end

    steady = 1'b0;
    settle();
    $display("covered %0d text bytes under %0d pattern settings, lengths 0 to 63, both case modes",
             verdicts.bytes_seen, settings);
    $display("checked %0d verdicts: %0d matching lines, %0d stream ends",
             verdicts.checked, verdicts.lines_hit, verdicts.stream_ends);
    if (verdicts.errors == 0 && verdicts.due.size() == 0) begin
      $display("tb_line_substring_matcher_unit passed");
    end else begin
      $display("tb_line_substring_matcher_unit failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/lsm_pkg.sv
rtl/core/lsm_cfg_regs.sv
rtl/core/lsm_window_match.sv
rtl/core/line_substring_matcher_unit.sv
bench/tb_line_substring_matcher_unit.sv
